>>> hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Used by bpa_map_ram and bitmap_page_allocator_core; no dependencies.
package bpa_pkg;

  localparam int unsigned PAGES       = 32768;
  localparam int unsigned MIN_PAGES   = 1024;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam logic [47:0] BASE_ADDR   = 48'd1048576;
  localparam int unsigned MAP_BYTES   = PAGES / 8;
  localparam int unsigned BYTE_AW     = $clog2(MAP_BYTES);
  localparam int unsigned IDX_W       = 16;
  localparam logic [36:0] BASE_PAGE   = 37'(BASE_ADDR >> PAGE_SHIFT);
  localparam logic [7:0]  BYTE_FULL   = 8'hFF;

  localparam logic [2:0] MODE_INIT = 3'd0;
  localparam logic [2:0] MODE_ONE  = 3'd1;
  localparam logic [2:0] MODE_NEXT = 3'd2;
  localparam logic [2:0] MODE_LOW  = 3'd3;
  localparam logic [2:0] MODE_FREE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_FELLBACK = 2'd3;

  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_KEND   = 2'd1;
  localparam logic [1:0] REG_TABLE  = 2'd2;
  localparam logic [1:0] REG_LOWLIM = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] count;
    logic [47:0] address;
  } bpa_in_t;

  typedef struct packed {
    logic [47:0] result_address;
    logic [1:0]  status;
    logic [15:0] pages_total;
    logic [47:0] top_address;
  } bpa_out_t;

  // Absolute page number to a page index relative to the base, clamped to [0, PAGES].
  function automatic logic [IDX_W-1:0] rel_page(input logic [36:0] abs_page);
    logic [36:0] diff;
    diff = abs_page - BASE_PAGE;
    if (abs_page <= BASE_PAGE) return '0;
    else if (diff > 37'(PAGES)) return IDX_W'(PAGES);
    else return diff[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/bpa_map_ram.sv
// Page map storage: one used bit per page, eight pages per byte entry.
// Depends on bpa_pkg; one write port and one registered read port.
module bpa_map_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bpa_pkg::BYTE_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [bpa_pkg::BYTE_AW-1:0] raddr,
  output logic [7:0]                 rdata
);
  import bpa_pkg::*;

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bitmap_page_allocator_core.sv
// Top level of the bitmap page allocator: command sequencer around the page map.
// Depends on bpa_pkg and bpa_map_ram.
//
// Usage: raise start with a command on in_data while busy is low; the command is
// taken at that edge; busy rises unless rejected. When done, out_valid is high
// for exactly one cycle with out_data; the same cycle busy is low again, so the
// next command may be issued right then. The receiver cannot stall results.
// Configuration registers are written over cfg_valid/cfg_ready (always ready),
// cfg_index selecting the register; write them only while the block is idle.
// Each map access moves one byte of eight pages over the single map port.
//   free: one byte read and rewritten; bad mode, count or free address: rejected.
//   allocations: each byte scanned is read then evaluated, each marked byte is
//   read then rewritten; a next-fit search that wraps scans up to twice.
//   init: states S_INIT1 to S_INIT3, then a sweep that rewrites the whole map.
// After reset the block clears the whole map with busy high.
module bitmap_page_allocator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bpa_pkg::bpa_in_t  in_data,
  output logic              out_valid,
  output bpa_pkg::bpa_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_data
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT1, S_INIT2, S_INIT3, S_SWEEP,
    S_SC_RD, S_SC_EV, S_MK_RD, S_MK_WR, S_FR_RD, S_FR_WR
  } state_t;

  state_t             state_r;
  logic [BYTE_AW-1:0] byte_r;
  logic [2:0]         mode_r;
  logic [IDX_W-1:0]   cnt_r, from_r, end_r, run_r, start_r, mend_r;
  logic               second_r;
  logic [2:0]         bit_r;
  logic [IDX_W-1:0]   pages_r, ipages_r, kr_r, ts_r, te_r;
  logic [47:0]        top_r;
  logic [14:0]        nfs_r;
  logic               fb_r;
  logic [47:0]        cfg_top_r, cfg_kend_r, cfg_table_r, cfg_low_r;
  logic               out_valid_r;
  logic [47:0]        out_addr_r;
  logic [1:0]         out_status_r;

  logic               mem_we;
  logic [7:0]         mem_wdata, mem_rdata;

  bpa_map_ram u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_r),
    .wdata (mem_wdata),
    .raddr (byte_r),
    .rdata (mem_rdata)
  );

  // Base index of the byte after the current one.
  logic [IDX_W-1:0] next_base;
  assign next_base = IDX_W'({({1'b0, byte_r} + (BYTE_AW + 1)'(1)), 3'b000});

  // Run search over one map byte.
  logic [IDX_W-1:0] ev_run, ev_start;
  logic             ev_found;
  always_comb begin
    logic [IDX_W-1:0] idx;
    ev_run   = run_r;
    ev_found = 1'b0;
    ev_start = '0;
    for (int b = 0; b < 8; b++) begin
      idx = IDX_W'({byte_r, 3'(b)});
      if (!ev_found && idx >= from_r && idx < end_r) begin
        if (mem_rdata[b]) begin
          ev_run = '0;
        end else begin
          ev_run = ev_run + IDX_W'(1);
          if (ev_run == cnt_r) begin
            ev_found = 1'b1;
            ev_start = idx + IDX_W'(1) - cnt_r;
          end
        end
      end
    end
  end

  // Mark and init-sweep byte masks.
  logic [7:0] mark_mask, sweep_mask;
  always_comb begin
    logic [IDX_W-1:0] idx;
    for (int b = 0; b < 8; b++) begin
      idx = IDX_W'({byte_r, 3'(b)});
      mark_mask[b]  = (idx >= start_r) && (idx < mend_r);
      sweep_mask[b] = (idx < pages_r) &&
                      ((idx < kr_r) || ((idx >= ts_r) && (idx < te_r)));
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = sweep_mask;
      end
      S_MK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | mark_mask;
      end
      S_FR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(8'd1 << bit_r);
      end
      default: ;
    endcase
  end

  // Command decode helpers.
  logic [47:0] low_diff, free_diff;
  logic [35:0] low_q, free_idx;
  logic [IDX_W-1:0] low_end;
  logic cnt_bad, free_ok;
  assign cnt_bad   = (in_data.count == '0) || (in_data.count > pages_r);
  assign low_diff  = cfg_low_r - BASE_ADDR;
  assign low_q     = low_diff[47:PAGE_SHIFT];
  assign low_end   = (cfg_low_r < BASE_ADDR) ? '0 :
                     (low_q > 36'(pages_r)) ? pages_r : low_q[IDX_W-1:0];
  assign free_diff = in_data.address - BASE_ADDR;
  assign free_idx  = free_diff[47:PAGE_SHIFT];
  assign free_ok   = (in_data.address >= BASE_ADDR) && (free_idx < 36'(pages_r));

  // Init sizing.
  logic [47:0] top_diff;
  logic [35:0] top_q;
  logic [IDX_W-1:0] clamp_p;
  assign top_diff = cfg_top_r - BASE_ADDR;
  assign top_q    = top_diff[47:PAGE_SHIFT];
  assign clamp_p  = (top_q > 36'(PAGES)) ? IDX_W'(PAGES) :
                    (top_q < 36'(MIN_PAGES)) ? IDX_W'(MIN_PAGES) : top_q[IDX_W-1:0];

  logic [12:0] ibytes, pbytes;
  logic [48:0] map_end, kend_up, tend_up;
  logic        map_over;
  assign ibytes   = 13'((17'(ipages_r) + 17'd7) >> 3);
  assign pbytes   = 13'((17'(pages_r) + 17'd7) >> 3);
  assign map_end  = {1'b0, cfg_table_r} + 49'(ibytes);
  assign map_over = map_end > 49'(BASE_ADDR);
  assign kend_up  = {1'b0, cfg_kend_r} + 49'((1 << PAGE_SHIFT) - 1);
  assign tend_up  = {1'b0, cfg_table_r} + 49'(pbytes) + 49'((1 << PAGE_SHIFT) - 1);

  logic [IDX_W-1:0] fin_p, mend_next;
  assign fin_p = (!fb_r && map_over) ? IDX_W'(MIN_PAGES) : ipages_r;
  assign mend_next = ev_start + cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      byte_r      <= '0;
      out_valid_r <= 1'b0;
      pages_r     <= IDX_W'(MIN_PAGES);
      top_r       <= BASE_ADDR + 48'(48'(MIN_PAGES) << PAGE_SHIFT);
      nfs_r       <= '0;
      cfg_top_r   <= 48'd5242880;
      cfg_kend_r  <= 48'd1048576;
      cfg_table_r <= 48'd589824;
      cfg_low_r   <= 48'd16777216;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TOP:    cfg_top_r   <= cfg_data;
          REG_KEND:   cfg_kend_r  <= cfg_data;
          REG_TABLE:  cfg_table_r <= cfg_data;
          REG_LOWLIM: cfg_low_r   <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          byte_r <= byte_r + BYTE_AW'(1);
          if (byte_r == BYTE_AW'(MAP_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            mode_r     <= in_data.mode;
            run_r      <= '0;
            out_addr_r <= '0;
            unique case (in_data.mode)
              MODE_INIT: state_r <= S_INIT1;
              MODE_ONE: begin
                cnt_r    <= IDX_W'(1);
                end_r    <= pages_r;
                from_r   <= '0;
                byte_r   <= '0;
                second_r <= 1'b1;
                state_r  <= S_SC_RD;
              end
              MODE_NEXT: begin
                cnt_r <= in_data.count;
                end_r <= pages_r;
                if (cnt_bad) begin
                  out_status_r <= ST_NOFIT;
                  out_valid_r  <= 1'b1;
                end else begin
                  from_r   <= IDX_W'(nfs_r);
                  byte_r   <= nfs_r[14:3];
                  second_r <= 1'b0;
                  state_r  <= S_SC_RD;
                end
              end
              MODE_LOW: begin
                cnt_r    <= in_data.count;
                end_r    <= low_end;
                from_r   <= '0;
                byte_r   <= '0;
                second_r <= 1'b1;
                if (cnt_bad) begin
                  out_status_r <= ST_NOFIT;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= S_SC_RD;
                end
              end
              MODE_FREE: begin
                if (free_ok) begin
                  byte_r  <= free_idx[14:3];
                  bit_r   <= free_idx[2:0];
                  state_r <= S_FR_RD;
                end else begin
                  out_status_r <= ST_IGNORED;
                  out_valid_r  <= 1'b1;
                end
              end
              default: begin
                out_status_r <= ST_IGNORED;
                out_valid_r  <= 1'b1;
              end
            endcase
          end
        end
        S_INIT1: begin
          if (cfg_top_r > BASE_ADDR) begin
            ipages_r <= clamp_p;
            fb_r     <= 1'b0;
          end else begin
            ipages_r <= IDX_W'(MIN_PAGES);
            fb_r     <= 1'b1;
          end
          state_r <= S_INIT2;
        end
        S_INIT2: begin
          if (!fb_r && map_over) fb_r <= 1'b1;
          pages_r <= fin_p;
          top_r   <= BASE_ADDR + 48'(48'(fin_p) << PAGE_SHIFT);
          kr_r    <= rel_page(kend_up[48:PAGE_SHIFT]);
          state_r <= S_INIT3;
        end
        S_INIT3: begin
          ts_r    <= rel_page(37'(cfg_table_r[47:PAGE_SHIFT]));
          te_r    <= rel_page(tend_up[48:PAGE_SHIFT]);
          byte_r  <= '0;
          state_r <= S_SWEEP;
        end
        S_SWEEP: begin
          byte_r <= byte_r + BYTE_AW'(1);
          if (byte_r == BYTE_AW'(MAP_BYTES - 1)) begin
            out_status_r <= fb_r ? ST_FELLBACK : ST_OK;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SC_RD: begin
          if (from_r >= end_r) begin
            if (!second_r) begin
              second_r <= 1'b1;
              from_r   <= '0;
              byte_r   <= '0;
              run_r    <= '0;
            end else begin
              out_status_r <= ST_NOFIT;
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            state_r <= S_SC_EV;
          end
        end
        S_SC_EV: begin
          run_r <= ev_run;
          if (ev_found) begin
            start_r <= ev_start;
            mend_r  <= mend_next;
            byte_r  <= ev_start[14:3];
            state_r <= S_MK_RD;
          end else if (next_base >= end_r) begin
            if (!second_r) begin
              second_r <= 1'b1;
              from_r   <= '0;
              byte_r   <= '0;
              run_r    <= '0;
              state_r  <= S_SC_RD;
            end else begin
              out_status_r <= ST_NOFIT;
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            byte_r  <= byte_r + BYTE_AW'(1);
            state_r <= S_SC_RD;
          end
        end
        S_MK_RD: begin
          state_r <= S_MK_WR;
        end
        S_MK_WR: begin
          if (next_base >= mend_r) begin
            out_addr_r   <= BASE_ADDR + 48'(48'(start_r) << PAGE_SHIFT);
            out_status_r <= ST_OK;
            out_valid_r  <= 1'b1;
            if (mode_r == MODE_NEXT) begin
              nfs_r <= (mend_r == pages_r) ? '0 : mend_r[14:0];
            end
            state_r <= S_IDLE;
          end else begin
            byte_r  <= byte_r + BYTE_AW'(1);
            state_r <= S_MK_RD;
          end
        end
        S_FR_RD: begin
          state_r <= S_FR_WR;
        end
        S_FR_WR: begin
          out_status_r <= ST_OK;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data.result_address = out_addr_r;
  assign out_data.status         = out_status_r;
  assign out_data.pages_total    = pages_r;
  assign out_data.top_address    = top_r;

endmodule
